// ===== rtl/mtt_pkg.sv =====
// Shared codes and field widths for the timer table.
package mtt_pkg;

   // Fixed field widths
   localparam int OP_W     = 2;
   localparam int ID_W     = 16;
   localparam int PERIOD_W = 16;
   localparam int STATUS_W = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_SET   = 2'd0;
   localparam logic [OP_W-1:0] OP_DROP  = 2'd1;
   localparam logic [OP_W-1:0] OP_START = 2'd2;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   // Result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FIRED  = 1'b1;

endpackage

// ===== rtl/multi_timer_table.sv =====
// Timer table top level: entry memory, lookup / tick / compaction sequencer.
// Set, drop, start: lookup reads one entry per cycle, then the status result is returned;
//   drop also moves each of the entries behind the dropped one down a slot.
// Tick: one entry per cycle through the read port, unless the output stalls;
//   the last expiry can also wait on output stalls. One request at a time.
// Reset empties the table at once (entry count cleared, no memory sweep).
module multi_timer_table #(
   parameter int NUM_TIMERS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mtt_pkg::OP_W-1:0]      req_op,
   input  logic [mtt_pkg::ID_W-1:0]      req_timer_id,
   input  logic [mtt_pkg::PERIOD_W-1:0]  req_period,
   input  logic                          req_auto_start,
   input  logic                          req_auto_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_kind,
   output logic [mtt_pkg::ID_W-1:0]      rsp_fired_id,
   output logic [mtt_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_last
);
   import mtt_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_APPLY = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;
   localparam logic [2:0] S_TICK  = 3'd5;
   localparam logic [2:0] S_FLUSH = 3'd6;

   typedef struct packed {
      logic [ID_W-1:0]       id;
      logic [COUNT_BITS-1:0] reload;
      logic [COUNT_BITS-1:0] count;
      logic                  repeat_en;
   } entry_type;

   // Entry memory
   entry_type            mem [NUM_TIMERS];
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   entry_type            wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   entry_type            rd_data_ff;

   // Control state
   logic [2:0]           state_ff, state_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic                 dvalid_ff, dvalid_in;
   logic [IDX_W-1:0]     daddr_ff, daddr_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   entry_type            hit_ff, hit_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]      pend_id_ff, pend_id_in;

   // Latched request
   logic [OP_W-1:0]       op_ff, op_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [COUNT_BITS-1:0] period_ff, period_in;
   logic                  start_ff, start_in;
   logic                  repeat_ff, repeat_in;
   logic [31:0]           period_ext;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  expire;
   logic                  stall;
   logic [COUNT_BITS-1:0] cnt_dec;
   entry_type             tick_entry;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign period_ext = {16'd0, req_period};

   // Tick datapath on the entry just read
   assign cnt_dec = rd_data_ff.count - 1'b1;
   assign expire  = dvalid_ff && (rd_data_ff.count != '0) && (cnt_dec == '0);
   assign stall   = expire && pend_valid_ff && !out_free;

   always_comb begin
      tick_entry = rd_data_ff;
      if (expire) begin
         tick_entry.count = rd_data_ff.repeat_en ? rd_data_ff.reload : '0;
      end else begin
         tick_entry.count = cnt_dec;
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      ptr_in        = ptr_ff;
      dvalid_in     = 1'b0;
      daddr_in      = daddr_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      hit_in        = hit_ff;
      status_in     = status_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      period_in     = period_ff;
      start_in      = start_ff;
      repeat_in     = repeat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_op;
               id_in         = req_timer_id;
               period_in     = period_ext[COUNT_BITS-1:0];
               start_in      = req_auto_start;
               repeat_in     = req_auto_restart;
               ptr_in        = '0;
               pend_valid_in = 1'b0;
               state_in      = (req_op == OP_TICK) ? S_TICK : S_SCAN;
            end
         end

         // Walk the table for the first matching ID
         S_SCAN: begin
            if (dvalid_ff && rd_data_ff.id == id_ff) begin
               found_in = 1'b1;
               slot_in  = daddr_ff;
               hit_in   = rd_data_ff;
               state_in = S_APPLY;
            end else if (ptr_ff < used_ff) begin
               rd_en     = 1'b1;
               daddr_in  = ptr_ff[IDX_W-1:0];
               ptr_in    = ptr_ff + 1'b1;
               dvalid_in = 1'b1;
            end else if (!dvalid_ff) begin
               found_in = 1'b0;
               state_in = S_APPLY;
            end
         end

         S_APPLY: begin
            status_in = ST_OK;
            state_in  = S_RESP;
            case (op_ff)
               OP_SET: begin
                  wr_data.id        = id_ff;
                  wr_data.reload    = period_ff;
                  wr_data.repeat_en = repeat_ff;
                  if (found_ff) begin
                     wr_en         = 1'b1;
                     wr_addr       = slot_ff;
                     wr_data.count = start_ff ? period_ff : '0;
                  end else if (used_ff < CNT_W'(NUM_TIMERS)) begin
                     wr_en         = 1'b1;
                     wr_addr       = used_ff[IDX_W-1:0];
                     wr_data.count = period_ff;
                     used_in       = used_ff + 1'b1;
                  end else begin
                     status_in = ST_FULL;
                  end
               end
               OP_START: begin
                  if (found_ff) begin
                     wr_en         = 1'b1;
                     wr_addr       = slot_ff;
                     wr_data       = hit_ff;
                     wr_data.count = hit_ff.reload;
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
               OP_DROP: begin
                  if (found_ff) begin
                     ptr_in   = CNT_W'(slot_ff) + 1'b1;
                     state_in = S_SHIFT;
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
               default: begin
                  status_in = ST_OK;
               end
            endcase
         end

         // Close the gap: each entry behind the dropped one moves down a slot
         S_SHIFT: begin
            if (dvalid_ff) begin
               wr_en   = 1'b1;
               wr_addr = daddr_ff - 1'b1;
               wr_data = rd_data_ff;
            end
            if (ptr_ff < used_ff) begin
               rd_en     = 1'b1;
               daddr_in  = ptr_ff[IDX_W-1:0];
               ptr_in    = ptr_ff + 1'b1;
               dvalid_in = 1'b1;
            end else if (!dvalid_ff) begin
               used_in  = used_ff - 1'b1;
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_STATUS;
               rsp_id_in     = '0;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         // Decrement pass; one expiry is held back so the last can be flagged
         S_TICK: begin
            if (stall) begin
               dvalid_in = dvalid_ff;
            end else begin
               if (dvalid_ff) begin
                  wr_en   = (rd_data_ff.count != '0);
                  wr_addr = daddr_ff;
                  wr_data = tick_entry;
                  if (expire) begin
                     if (pend_valid_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = KIND_FIRED;
                        rsp_id_in     = pend_id_ff;
                        rsp_status_in = ST_OK;
                        rsp_last_in   = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_id_in    = rd_data_ff.id;
                  end
               end
               if (ptr_ff < used_ff) begin
                  rd_en     = 1'b1;
                  daddr_in  = ptr_ff[IDX_W-1:0];
                  ptr_in    = ptr_ff + 1'b1;
                  dvalid_in = 1'b1;
               end else if (!dvalid_ff) begin
                  state_in = S_FLUSH;
               end
            end
         end

         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_FIRED;
               rsp_id_in     = pend_id_ff;
               rsp_status_in = ST_OK;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         dvalid_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         dvalid_ff     <= dvalid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      daddr_ff      <= daddr_in;
      found_ff      <= found_in;
      slot_ff       <= slot_in;
      hit_ff        <= hit_in;
      status_ff     <= status_in;
      pend_id_ff    <= pend_id_in;
      op_ff         <= op_in;
      id_ff         <= id_in;
      period_ff     <= period_in;
      start_ff      <= start_in;
      repeat_ff     <= repeat_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_fired_id = rsp_id_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== rtl/mtt_checker.sv =====
// Port-level assertions for the timer table, bound to the top level.
module mtt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_kind,
   input logic [mtt_pkg::ID_W-1:0]      rsp_fired_id,
   input logic [mtt_pkg::STATUS_W-1:0]  rsp_status,
   input logic                          rsp_last
);
   import mtt_pkg::*;

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_fired_id) && $stable(rsp_status) && $stable(rsp_last))
      else $error("result changed while stalled");

   // A status result is a lone, final result with no ID
   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATUS |-> rsp_last && rsp_fired_id == '0)
      else $error("malformed status result");

   // Expiry results carry ok status; status codes stay in range
   a_fired_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_STATUS || rsp_status == ST_OK) &&
      (rsp_status == ST_OK || rsp_status == ST_NOT_FOUND || rsp_status == ST_FULL))
      else $error("bad status code");

   // No result in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

   // A request is never taken while the previous one still sends non-final expiries
   a_no_accept_mid_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FIRED && !rsp_last && rsp_ready |-> !req_ready)
      else $error("request taken during a tick");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (.*);
